[src/skt_pkg.sv]
`default_nettype none

package skt_pkg;

  // command codes
  localparam logic [1:0] CMD_SEARCH = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_RANGE     = 2'd3;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_INS_RD,
    S_INS_CMP,
    S_SHUP_RD,
    S_SHUP_WR,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_DONE
  } state_t;

  // result of one request
  typedef struct packed {
    logic [5:0] position_res;
    logic [1:0] status;
    logic [5:0] entry_count;
  } res_t;

endpackage

`default_nettype wire

[src/skt_ifs.sv]
`default_nettype none

// request channel
interface skt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [63:0] key;
  logic [7:0]  position;

  modport source (output valid, output cmd, output key, output position, input ready);
  modport sink (input valid, input cmd, input key, input position, output ready);
endinterface

// result channel
interface skt_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] position_res;
  logic [1:0] status;
  logic [5:0] entry_count;

  modport source (output valid, output position_res, output status, output entry_count,
                  input ready);
  modport sink (input valid, input position_res, input status, input entry_count,
                output ready);
endinterface

`default_nettype wire

[src/skt_key_ram.sv]
`default_nettype none

module skt_key_ram #(
  parameter int DEPTH = 63,
  parameter int WIDTH = 64,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/skt_ctrl.sv]
`default_nettype none

module skt_ctrl #(
  parameter int CAPACITY = 63,
  parameter int KW       = 64,
  parameter int AW       = 6,
  parameter int CW       = 6
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  skt_in_if.sink             in_req,
  skt_out_if.source          out_res,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic [KW-1:0]      mem_wdata,
  output logic [AW-1:0]      mem_raddr,
  input  wire logic [KW-1:0] mem_rdata
);

  import skt_pkg::*;

  localparam int RW = (CW > 6) ? CW : 6;
  localparam int PW = (CW > 8) ? CW : 8;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [KW-1:0] key_r, key_nxt;
  logic [CW-1:0] p_r, p_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [RW-1:0] rpos_r, rpos_nxt;
  logic [1:0]    rstat_r, rstat_nxt;
  res_t          res_r, res_nxt;

  logic          in_fire;
  logic [CW-1:0] p_dec;
  logic [CW-1:0] j_dec;
  logic [RW-1:0] cnt_ext;
  logic          del_bad;

  assign in_fire = in_req.valid && in_req.ready;
  assign p_dec   = p_r - CW'(1);
  assign j_dec   = j_r - CW'(1);
  assign cnt_ext = RW'(count_r);
  assign del_bad = (in_req.position == 8'd0) || (PW'(in_req.position) > PW'(count_r));

  // no request is taken while reset is held
  assign in_req.ready         = rst_n && (state_r == S_IDLE);
  assign out_res.valid        = out_valid_r;
  assign out_res.position_res = res_r.position_res;
  assign out_res.status       = res_r.status;
  assign out_res.entry_count  = res_r.entry_count;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    p_r     <= p_nxt;
    j_r     <= j_nxt;
    rpos_r  <= rpos_nxt;
    rstat_r <= rstat_nxt;
    res_r   <= res_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    key_nxt       = key_r;
    p_nxt         = p_r;
    j_nxt         = j_r;
    rpos_nxt      = rpos_r;
    rstat_nxt     = rstat_r;
    res_nxt       = res_r;
    mem_we        = 1'b0;
    mem_waddr     = p_dec[AW-1:0];
    mem_wdata     = mem_rdata;
    mem_raddr     = p_dec[AW-1:0];

    // result taken downstream
    if (out_valid_r && out_res.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          key_nxt   = in_req.key[KW-1:0];
          rpos_nxt  = '0;
          rstat_nxt = STAT_OK;
          state_nxt = S_DONE;
          case (in_req.cmd)
            CMD_SEARCH: begin
              if (count_r == '0) begin
                rstat_nxt = STAT_NOT_FOUND;
              end else begin
                p_nxt     = count_r;
                state_nxt = S_SRCH_RD;
              end
            end
            CMD_INSERT: begin
              p_nxt = CW'(1);
              if (count_r == CW'(CAPACITY)) begin
                rstat_nxt = STAT_FULL;
              end else if (count_r == '0) begin
                state_nxt = S_INS_WR;
              end else begin
                state_nxt = S_INS_RD;
              end
            end
            CMD_DELETE: begin
              if (del_bad) begin
                rstat_nxt = STAT_RANGE;
              end else begin
                p_nxt    = CW'(in_req.position);
                j_nxt    = CW'(in_req.position);
                rpos_nxt = RW'(in_req.position);
                if (CW'(in_req.position) == count_r) begin
                  count_nxt = count_r - CW'(1);
                end else begin
                  state_nxt = S_DEL_RD;
                end
              end
            end
            default: begin
              rstat_nxt = STAT_RANGE;
            end
          endcase
        end
      end

      // scan downward for the highest equal key
      S_SRCH_RD: begin
        state_nxt = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (mem_rdata == key_r) begin
          rpos_nxt  = RW'(p_r);
          state_nxt = S_DONE;
        end else if (p_r == CW'(1)) begin
          rstat_nxt = STAT_NOT_FOUND;
          state_nxt = S_DONE;
        end else begin
          p_nxt     = p_dec;
          state_nxt = S_SRCH_RD;
        end
      end

      // scan upward for the insert place
      S_INS_RD: begin
        state_nxt = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (mem_rdata < key_r) begin
          p_nxt = p_r + CW'(1);
          if (p_r == count_r) begin
            state_nxt = S_INS_WR;
          end else begin
            state_nxt = S_INS_RD;
          end
        end else begin
          j_nxt     = count_r;
          state_nxt = S_SHUP_RD;
        end
      end

      // move entries up one place, top first
      S_SHUP_RD: begin
        mem_raddr = j_dec[AW-1:0];
        state_nxt = S_SHUP_WR;
      end
      S_SHUP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = j_r[AW-1:0];
        if (j_r == p_r) begin
          state_nxt = S_INS_WR;
        end else begin
          j_nxt     = j_dec;
          state_nxt = S_SHUP_RD;
        end
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_wdata = key_r;
        count_nxt = count_r + CW'(1);
        rpos_nxt  = RW'(p_r);
        state_nxt = S_DONE;
      end

      // move entries down one place, bottom first
      S_DEL_RD: begin
        mem_raddr = j_r[AW-1:0];
        state_nxt = S_DEL_WR;
      end
      S_DEL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = j_dec[AW-1:0];
        j_nxt     = j_r + CW'(1);
        if (j_r + CW'(1) == count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DEL_RD;
        end
      end

      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || out_res.ready) begin
          res_nxt.position_res = rpos_r[5:0];
          res_nxt.status       = rstat_r;
          res_nxt.entry_count  = cnt_ext[5:0];
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != S_IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count_r) |-> !$past(rst_n) || $past(state_r) == S_INS_WR ||
      $past(state_r) == S_DEL_WR || $past(state_r) == S_IDLE)
    else $error("entry count changed outside insert or delete");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result loaded outside done state");

  a_fail_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.status != STAT_OK) |-> res_r.position_res == 6'd0)
    else $error("failed request reports a position");
`endif

endmodule

`default_nettype wire

[src/sorted_key_table_core.sv]
// search reads and compares entries from the top down; insert scans upward for its place,
//   moves the entries above it up one place, then writes the key; delete moves the entries
//   above the position down one place; each request then loads the result register
// one request at a time, set by the single read and single write port of the key memory
// a new request is taken while the previous result waits in the output register
// reset clears the entry count and the handshake state; the key memory is not cleared
`default_nettype none

module sorted_key_table_core #(
  parameter int CAPACITY  = 63,
  parameter int KEY_BYTES = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  skt_in_if.sink    in_req,
  skt_out_if.source out_res
);

  import skt_pkg::*;

  localparam int KW = 8 * KEY_BYTES;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [KW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [KW-1:0] mem_rdata;

  // sequencer
  skt_ctrl #(
    .CAPACITY (CAPACITY),
    .KW       (KW),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_res   (out_res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // key memory
  skt_key_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (KW),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

[tb/skt_checker.sv]
`default_nettype none

module skt_checker
  import skt_pkg::*;
#(
  parameter int CAPACITY  = 63,
  parameter int KEY_BYTES = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  skt_in_if         req_mon,
  skt_out_if        res_mon,
  output int        n_fail,
  output int        n_pending,
  output int        n_checked,
  output int        n_full
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - 8 * KEY_BYTES);

  // shadow copy of the sorted table
  logic [63:0] table_keys [CAPACITY];
  int          table_cnt;

  // results still owed by the block, oldest first
  res_t        owed_results [$];
  int          fails   = 0;
  int          checked = 0;
  int          fulls   = 0;

  // apply one request to the shadow table and return its result
  function automatic res_t table_update(logic [1:0] cmd, logic [63:0] key_in,
                                        logic [7:0] pos);
    res_t        r;
    logic [63:0] k;
    int          p;
    k              = key_in & KEY_MASK;
    r.position_res = '0;
    r.status       = STAT_OK;
    case (cmd)
      CMD_SEARCH: begin
        // highest matching position wins
        p = table_cnt;
        while (p > 0 && table_keys[p-1] != k) p--;
        r.position_res = 6'(p);
        if (p == 0) r.status = STAT_NOT_FOUND;
      end
      CMD_INSERT: begin
        if (table_cnt >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          // scan stops at the last held entry
          p = 1;
          while (p <= table_cnt && table_keys[p-1] < k) p++;
          for (int j = table_cnt; j >= p; j--) table_keys[j] = table_keys[j-1];
          table_keys[p-1] = k;
          table_cnt++;
          r.position_res = 6'(p);
        end
      end
      CMD_DELETE: begin
        if (pos < 1 || pos > table_cnt) begin
          r.status = STAT_RANGE;
        end else begin
          for (int j = pos; j < table_cnt; j++) table_keys[j-1] = table_keys[j];
          table_cnt--;
          r.position_res = 6'(pos);
        end
      end
      default: r.status = STAT_RANGE;
    endcase
    r.entry_count = 6'(table_cnt);
    return r;
  endfunction

  // compare results first, then record the new request of this edge
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      table_cnt = 0;
      owed_results.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        got.position_res = res_mon.position_res;
        got.status       = res_mon.status;
        got.entry_count  = res_mon.entry_count;
        if (owed_results.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("[%0t] unexpected result: pos %0d status %0d count %0d",
                     $realtime, got.position_res, got.status, got.entry_count);
        end else begin
          want = owed_results.pop_front();
          checked++;
          if (want.status == STAT_FULL) fulls++;
          if (got.position_res != want.position_res || got.status != want.status ||
              got.entry_count != want.entry_count) begin
            fails++;
            if (fails <= 10)
              $display("[%0t] result %0d: expected pos %0d status %0d count %0d, %s",
                       $realtime, checked, want.position_res, want.status,
                       want.entry_count,
                       $sformatf("got pos %0d status %0d count %0d",
                                 got.position_res, got.status, got.entry_count));
          end
        end
      end
      if (req_mon.valid && req_mon.ready)
        owed_results.push_back(table_update(req_mon.cmd, req_mon.key, req_mon.position));
    end
    n_fail    <= fails;
    n_pending <= owed_results.size();
    n_checked <= checked;
    n_full    <= fulls;
  end

endmodule

`default_nettype wire

[tb/tb_top.sv]
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import skt_pkg::*;

  localparam int         CAPACITY       = 63;
  localparam int         KEY_BYTES      = 8;
  localparam logic [1:0] CMD_UNUSED     = 2'd3;
  localparam int         POOL_SIZE      = 20;
  localparam int         RAND_PER_PHASE = 410;
  localparam int         SEGMENT        = 120;
  localparam int         TAIL_CYCLES    = 2 * CAPACITY + 20;

  logic      clk = 1'b0;
  logic      rst_n;
  skt_in_if  req_if ();
  skt_out_if res_if ();

  int          n_fail;
  int          n_pending;
  int          n_checked;
  int          n_full;
  int          idle_pct;
  int          stall_pct;
  bit          gap_pending;
  int          sent_cnt [4];
  logic [63:0] key_pool [POOL_SIZE];

  sorted_key_table_core #(
    .CAPACITY  (CAPACITY),
    .KEY_BYTES (KEY_BYTES)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_res (res_if)
  );

  skt_checker #(
    .CAPACITY  (CAPACITY),
    .KEY_BYTES (KEY_BYTES)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_mon   (req_if),
    .res_mon   (res_if),
    .n_fail    (n_fail),
    .n_pending (n_pending),
    .n_checked (n_checked),
    .n_full    (n_full)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk) begin
    res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // present one request and hold it until taken; valid stays up when no gap follows
  task automatic send_req(input logic [1:0] c, input logic [63:0] k, input logic [7:0] p);
    if (gap_pending) begin
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    req_if.valid    <= 1'b1;
    req_if.cmd      <= c;
    req_if.key      <= k;
    req_if.position <= p;
    do @(posedge clk); while (!req_if.ready);
    sent_cnt[c]++;
    gap_pending = ($urandom_range(99) < idle_pct);
    if (gap_pending) req_if.valid <= 1'b0;
  endtask

  // drop valid and wait until every owed result is back
  task automatic hold_off();
    if (!gap_pending) req_if.valid <= 1'b0;
    gap_pending = 1'b1;
    do @(posedge clk); while (n_pending != 0);
  endtask

  initial begin
    bit          filling;
    int          roll;
    int          len;
    logic [1:0]  c;
    logic [7:0]  p;
    logic [63:0] k;

    req_if.valid    = 1'b0;
    req_if.cmd      = CMD_SEARCH;
    req_if.key      = '0;
    req_if.position = '0;
    res_if.ready    = 1'b0;
    rst_n           = 1'b0;
    gap_pending     = 1'b1;
    idle_pct        = 0;
    stall_pct       = 0;
    foreach (sent_cnt[i]) sent_cnt[i] = 0;

    // key pool: extremes plus random names and raw values
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) begin
      if (i % 2 == 0) begin
        key_pool[i] = {$urandom, $urandom};
      end else begin
        key_pool[i] = '0;
        len = $urandom_range(1, 8);
        for (int b = 0; b < len; b++) key_pool[i][63-8*b -: 8] = 8'($urandom_range(65, 90));
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, ordering, duplicates, range errors, unused code
    send_req(CMD_SEARCH, 64'h0, 8'd0);
    send_req(CMD_DELETE, 64'h0, 8'd1);
    send_req(CMD_INSERT, 64'h0, 8'd0);
    send_req(CMD_INSERT, '1, 8'd0);
    send_req(CMD_INSERT, 64'h4142_4300_0000_0000, 8'd0);
    send_req(CMD_INSERT, 64'h4142_4300_0000_0000, 8'd0);
    send_req(CMD_INSERT, 64'h4142_4200_0000_0000, 8'd0);
    send_req(CMD_SEARCH, 64'h4142_4300_0000_0000, 8'd0);
    send_req(CMD_SEARCH, '1, 8'd0);
    send_req(CMD_SEARCH, 64'h4142_4400_0000_0000, 8'd0);
    send_req(CMD_DELETE, 64'h0, 8'd0);
    send_req(CMD_DELETE, 64'h0, 8'd255);
    send_req(CMD_DELETE, 64'h0, 8'd6);
    send_req(CMD_DELETE, 64'h0, 8'd5);
    send_req(CMD_DELETE, 64'h0, 8'd1);
    send_req(CMD_SEARCH, 64'h0, 8'd0);
    send_req(CMD_SEARCH, 64'h4142_4200_0000_0000, 8'd0);
    send_req(CMD_UNUSED, '1, 8'd1);
    send_req(CMD_INSERT, 64'h1, 8'd0);

    // random phases, alternating fill and drain segments
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 49; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      hold_off();
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        filling = ((i / SEGMENT) % 2 == 0);
        roll = $urandom_range(99);
        if (filling)
          c = (roll < 70) ? CMD_INSERT : (roll < 90) ? CMD_SEARCH : CMD_DELETE;
        else
          c = (roll < 70) ? CMD_DELETE : (roll < 90) ? CMD_SEARCH : CMD_INSERT;

        // delete positions: mostly near the front while draining
        roll = $urandom_range(99);
        if (roll < 5)
          p = 8'($urandom_range(255));
        else if (!filling && roll < 75)
          p = 8'($urandom_range(1, 4));
        else
          p = 8'($urandom_range(0, CAPACITY + 3));

        // keys: pool reuse for hits and duplicates, short names, raw values
        k = '0;
        case ($urandom_range(3))
          0, 1: k = key_pool[$urandom_range(POOL_SIZE - 1)];
          2: begin
            len = $urandom_range(1, 8);
            for (int b = 0; b < len; b++) k[63-8*b -: 8] = 8'($urandom_range(65, 90));
          end
          default: k = {$urandom, $urandom};
        endcase

        send_req(c, k, p);
      end
    end

    hold_off();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d requests: %0d search, %0d insert, %0d delete, %0d unused code",
             sent_cnt[0] + sent_cnt[1] + sent_cnt[2] + sent_cnt[3], sent_cnt[CMD_SEARCH],
             sent_cnt[CMD_INSERT], sent_cnt[CMD_DELETE], sent_cnt[CMD_UNUSED]);
    $display("%0d results compared, %0d inserts refused on a full table", n_checked, n_full);
    if (n_fail == 0 && n_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
